// ===== hdl/srr_pkg.sv =====
package srr_pkg;

  localparam int WIN_SIZE = 8;
  localparam int SEQ_BITS = 16;

  localparam int SEQ_W = 16;
  localparam int PAY_W = 64;
  localparam int IDX_W = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

endpackage

// ===== hdl/selective_repeat_receiver_core.sv =====
// Selective-repeat receiver: one packet request is taken at a time and in_ready_o stays low
// until every result it causes has been taken. A corrupt or out-of-range packet is dropped after
// the check; an acknowledge-only packet gives one acknowledge; an in-window packet gives its
// k delivered payloads and then an acknowledge, and the output can hold off each of them. Each
// delivery passes from the slot buffer's registered read into the output register. The
// receive window is a circular buffer, so sliding it moves only a pointer.
module selective_repeat_receiver_core
  import srr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic             checksum_ok_i,
  input  logic [PAY_W-1:0] payload_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [SEQ_W-1:0] ack_num_o,
  output logic [PAY_W-1:0] payload_out_o,
  output logic             last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_ACK   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SEQ_BITS-1:0] seq_q;
  logic                good_q;
  logic [PAY_W-1:0]    pay_q;
  logic [SEQ_BITS-1:0] base_q;
  logic [IDX_W-1:0]    ptr_q;
  logic [WIN_SIZE-1:0] held_q;

  logic                out_valid_q;
  logic                kind_q;
  logic [SEQ_W-1:0]    ack_q;
  logic [PAY_W-1:0]    pay_out_q;
  logic                last_q;

  logic [SEQ_BITS-1:0] ahead, behind;
  logic                in_win, in_prev;
  logic [IDX_W:0]      slot_sum, ptr_sum;
  logic [IDX_W-1:0]    slot_idx, ptr_inc;
  logic                ram_we, ram_re;
  logic [PAY_W-1:0]    ram_rdata;
  logic                in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // window position of the packet
  assign ahead   = seq_q - base_q;
  assign behind  = base_q - seq_q;
  assign in_win  = 32'(ahead) < 32'(WIN_SIZE);
  assign in_prev = (behind != '0) && (32'(behind) <= 32'(WIN_SIZE));

  // circular slot index
  assign slot_sum = (IDX_W+1)'(ptr_q) + (IDX_W+1)'(ahead);
  assign slot_idx = (32'(slot_sum) >= 32'(WIN_SIZE)) ?
                    IDX_W'(slot_sum - (IDX_W+1)'(WIN_SIZE)) : IDX_W'(slot_sum);
  assign ptr_sum  = (IDX_W+1)'(ptr_q) + (IDX_W+1)'(1);
  assign ptr_inc  = (32'(ptr_sum) >= 32'(WIN_SIZE)) ?
                    IDX_W'(ptr_sum - (IDX_W+1)'(WIN_SIZE)) : IDX_W'(ptr_sum);

  assign ram_we = (state_q == S_CHECK) && good_q && in_win && !held_q[slot_idx];
  assign ram_re = (state_q == S_READ) && held_q[ptr_q];

  srr_ram #(
    .WIDTH(PAY_W),
    .DEPTH(WIN_SIZE)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_idx),
    .wdata_i(pay_q),
    .re_i   (ram_re),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (!good_q) state_d = S_IDLE;
        else if (in_win)      state_d = S_READ;
        else if (in_prev)     state_d = S_ACK;
        else                  state_d = S_IDLE;
      end
      S_READ: begin
        state_d = held_q[ptr_q] ? S_LOAD : S_ACK;
      end
      S_LOAD: begin
        state_d = S_WAIT;
      end
      S_ACK: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (out_acc) state_d = last_q ? S_IDLE : S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= SEQ_BITS'(1);
      ptr_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        held_q[slot_idx] <= 1'b1;
      end
      if (ram_re) begin
        held_q[ptr_q] <= 1'b0;
        ptr_q         <= ptr_inc;
        base_q        <= base_q + SEQ_BITS'(1);
      end
      if (state_q == S_LOAD || state_q == S_ACK) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q  <= SEQ_BITS'(seq_num_i);
      good_q <= checksum_ok_i;
      pay_q  <= payload_in_i;
    end
    if (state_q == S_LOAD) begin
      kind_q    <= KIND_DELIVER;
      ack_q     <= '0;
      pay_out_q <= ram_rdata;
      last_q    <= 1'b0;
    end else if (state_q == S_ACK) begin
      kind_q    <= KIND_ACK;
      ack_q     <= SEQ_W'(seq_q);
      pay_out_q <= '0;
      last_q    <= 1'b1;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign ack_num_o     = ack_q;
  assign payload_out_o = pay_out_q;
  assign last_o        = last_q;

  // no request is taken while a result is pending
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready with a result pending");

  // a slot read is followed by loading its payload
  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == S_LOAD))
    else $error("slot read not followed by load");

  // acks close a packet, deliveries never do
  a_ack_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == KIND_ACK)))
    else $error("last flag does not match result kind");

  // the window slides by one with each delivery
  a_base_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (base_q == $past(base_q) + SEQ_BITS'(1)))
    else $error("window base did not advance");

  // a slot is written only while free, and is then marked held
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> held_q[$past(slot_idx)])
    else $error("written slot not marked held");

endmodule

// ===== hdl/srr_ram.sv =====
module srr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/selective_repeat_receiver_core_tb.sv =====
`timescale 1ns / 100ps

module selective_repeat_receiver_core_tb;
  import srr_pkg::*;

  localparam int GAP_MAX     = 18;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQS = 330;
  localparam int DRAIN_WAIT  = 40;
  localparam int NUM_ROWS    = 23;
  localparam int PREDICTED   = -1;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] ack_num;
    logic [PAY_W-1:0] payload;
    logic             last;
  } rx_result_t;

  typedef struct {
    logic [SEQ_W-1:0] seq;
    logic             ok;
    logic [PAY_W-1:0] word;
    int               typed_results;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [SEQ_W-1:0] seq_num_i = '0;
  logic             checksum_ok_i = 1'b0;
  logic [PAY_W-1:0] payload_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             kind_o;
  logic [SEQ_W-1:0] ack_num_o;
  logic [PAY_W-1:0] payload_out_o;
  logic             last_o;

  logic [SEQ_BITS-1:0] win_base = SEQ_BITS'(1);
  logic [PAY_W-1:0]    slot_word [WIN_SIZE];
  logic                slot_full [WIN_SIZE];

  rx_result_t step_results [$];
  rx_result_t awaited_results [$];
  stim_row_t  directed_rows [NUM_ROWS];

  int fail_count = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit quiet = 1'b0;

  selective_repeat_receiver_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_in_i  (payload_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .ack_num_o     (ack_num_o),
    .payload_out_o (payload_out_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receive window: buffer, deliver the in-order run, slide, acknowledge; re-ack the previous window
  function automatic void window_receive(logic [SEQ_W-1:0] seq, logic ok,
                                         logic [PAY_W-1:0] word);
    logic [SEQ_BITS-1:0] s;
    logic [SEQ_BITS-1:0] ahead;
    logic [SEQ_BITS-1:0] behind;
    int run;
    step_results.delete();
    s = seq[SEQ_BITS-1:0];
    ahead = s - win_base;
    behind = win_base - s;
    run = 0;
    if (!ok) return;
    if (ahead < WIN_SIZE) begin
      if (!slot_full[ahead]) begin
        slot_word[ahead] = word;
        slot_full[ahead] = 1'b1;
      end
      while (run < WIN_SIZE && slot_full[run]) run++;
      for (int i = 0; i < run; i++) begin
        step_results.push_back(rx_result_t'{KIND_DELIVER, '0, slot_word[i], 1'b0});
      end
      for (int i = 0; i < WIN_SIZE; i++) begin
        if (i + run < WIN_SIZE) begin
          slot_word[i] = slot_word[i + run];
          slot_full[i] = slot_full[i + run];
        end else begin
          slot_word[i] = '0;
          slot_full[i] = 1'b0;
        end
      end
      win_base = win_base + SEQ_BITS'(run);
      step_results.push_back(rx_result_t'{KIND_ACK, SEQ_W'(s), '0, 1'b1});
    end else if (behind >= 1 && behind <= WIN_SIZE) begin
      step_results.push_back(rx_result_t'{KIND_ACK, SEQ_W'(s), '0, 1'b1});
    end
  endfunction

  task automatic offer_packet(input logic [SEQ_W-1:0] seq, input logic ok,
                              input logic [PAY_W-1:0] word, input int typed_results);
    in_valid_i <= 1'b1;
    seq_num_i <= seq;
    checksum_ok_i <= ok;
    payload_in_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    window_receive(seq, ok, word);
    if (typed_results == PREDICTED) begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end else begin
      if (typed_results == 2) begin
        awaited_results.push_back(rx_result_t'{KIND_DELIVER, '0, word, 1'b0});
      end
      if (typed_results >= 1) begin
        awaited_results.push_back(rx_result_t'{KIND_ACK, seq, '0, 1'b1});
      end
    end
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk_i);
    end
  endtask

  task automatic random_packet();
    logic [SEQ_BITS-1:0] s;
    logic                ok;
    logic [PAY_W-1:0]    word;
    int                  pick;
    pick = $urandom_range(0, 99);
    ok = 1'b1;
    word = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) word = '1;
    else if ($urandom_range(0, 15) == 0) word = '0;
    if (pick < 70) begin
      s = win_base + SEQ_BITS'($urandom_range(0, WIN_SIZE - 1));
    end else if (pick < 80) begin
      s = win_base - SEQ_BITS'($urandom_range(1, WIN_SIZE));
    end else if (pick < 88) begin
      s = win_base + SEQ_BITS'($urandom_range(0, WIN_SIZE - 1));
      ok = 1'b0;
    end else if (pick < 94) begin
      s = win_base + SEQ_BITS'($urandom_range(WIN_SIZE, WIN_SIZE + 12));
    end else begin
      s = SEQ_BITS'($urandom_range(0, 65535));
      ok = 1'($urandom_range(0, 1));
    end
    offer_packet(SEQ_W'(s), ok, word, PREDICTED);
  endtask

  // response side: random ready bursts, one long hold-off on request
  initial begin : response_side
    int len;
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (quiet) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        len = $urandom_range(1, GAP_MAX);
        out_ready_i <= ($urandom_range(0, 2) != 0);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    rx_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d ack_num %0d payload_out %h last %0d",
               kind_o, ack_num_o, payload_out_o, last_o);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fail_count++;
        end
        if (ack_num_o !== want.ack_num) begin
          $error("ack_num: expected %0d, got %0d", want.ack_num, ack_num_o);
          fail_count++;
        end
        if (payload_out_o !== want.payload) begin
          $error("payload_out: expected %h, got %h", want.payload, payload_out_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < WIN_SIZE; i++) begin
      slot_word[i] = '0;
      slot_full[i] = 1'b0;
    end
    directed_rows = '{
      '{16'd1,      1'b0, 64'h0123_4567_89ab_cdef, 0},
      '{16'd9,      1'b1, 64'h1111_2222_3333_4444, 0},
      '{16'd0,      1'b1, 64'h0000_0000_0000_0000, 1},
      '{16'hfff9,   1'b1, 64'hffff_0000_ffff_0000, 1},
      '{16'hfff8,   1'b1, 64'h0000_ffff_0000_ffff, 0},
      '{16'd1,      1'b1, 64'hffff_ffff_ffff_ffff, 2},
      '{16'd3,      1'b1, 64'h0000_0000_0000_0000, 1},
      '{16'd3,      1'b1, 64'ha5a5_a5a5_a5a5_a5a5, 1},
      '{16'd4,      1'b1, 64'h5a5a_5a5a_5a5a_5a5a, 1},
      '{16'd5,      1'b1, 64'h0123_4567_89ab_cdef, 1},
      '{16'd6,      1'b1, 64'h8000_0000_0000_0000, 1},
      '{16'd7,      1'b1, 64'h0000_0000_0000_0001, 1},
      '{16'd8,      1'b1, 64'hfedc_ba98_7654_3210, 1},
      '{16'd9,      1'b1, 64'h7fff_ffff_ffff_ffff, 1},
      '{16'd10,     1'b1, 64'h1234_1234_1234_1234, 0},
      '{16'd2,      1'b1, 64'hdead_beef_cafe_f00d, PREDICTED},
      '{16'd10,     1'b0, 64'h5555_5555_5555_5555, 0},
      '{16'd18,     1'b1, 64'haaaa_aaaa_aaaa_aaaa, 0},
      '{16'd2,      1'b1, 64'h0f0f_0f0f_0f0f_0f0f, 1},
      '{16'd1,      1'b1, 64'hf0f0_f0f0_f0f0_f0f0, 0},
      '{16'h8000,   1'b1, 64'h3333_3333_3333_3333, 0},
      '{16'd11,     1'b1, 64'hc3c3_c3c3_c3c3_c3c3, 1},
      '{16'd10,     1'b1, 64'h3c3c_3c3c_3c3c_3c3c, PREDICTED}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      sender_gap();
      offer_packet(directed_rows[i].seq, directed_rows[i].ok, directed_rows[i].word,
                   directed_rows[i].typed_results);
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 100) begin
        // drain everything before going on
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (awaited_results.size() != 0);
      end
      if (n == 150) long_hold = 1'b1;
      if (n == RANDOM_REQS - 60) quiet = 1'b1;
      sender_gap();
      random_packet();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/srr_pkg.sv
hdl/srr_ram.sv
hdl/selective_repeat_receiver_core.sv
tb/sv/selective_repeat_receiver_core_tb.sv
